// ----- hw/rtl/bsm_pkg.sv -----
`default_nettype none

package bsm_pkg;

  // Offset widths of the mapped windows (defaults for the top level parameters)
  localparam int PRG_OFFSET_BITS_DEF = 19;
  localparam int CHR_OFFSET_BITS_DEF = 18;

  localparam int OFFSET_W    = 19;
  localparam int BANK_W      = 8;
  localparam int PRG_IDX_W   = 6;
  localparam int PRG_N_W     = 7;
  localparam int CHR_N_W     = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  // Command codes of a request word
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_VIDEO = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Target codes of a response word
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_CHR  = 2'd1;
  localparam logic [1:0] TGT_PRG  = 2'd2;
  localparam logic [1:0] TGT_SRAM = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANK_COUNT = 2'd1;

  localparam logic [PRG_N_W-1:0] PRG_N_MIN   = 7'd2;
  localparam logic [PRG_N_W-1:0] PRG_N_MAX   = 7'd64;
  localparam logic [CHR_N_W-1:0] CHR_N_MIN   = 9'd8;
  localparam logic [CHR_N_W-1:0] CHR_N_MAX   = 9'd256;

  // Scanline counter clocking window
  localparam logic [8:0] IRQ_DOT      = 9'd280;
  localparam logic [8:0] VBLANK_FIRST = 9'd240;
  localparam logic [8:0] VBLANK_LAST  = 9'd260;

  // Fixed program banks: second to last and last
  localparam logic [BANK_W-1:0] PRG_BANK_SECOND_LAST = 8'hFE;
  localparam logic [BANK_W-1:0] PRG_BANK_LAST        = 8'hFF;

  // Bank index sweep: 8 character entries, then 4 program entries
  localparam int ENTRY_W   = 4;
  localparam int STEP_W    = 4;
  localparam int DIV_STEPS = BANK_W;
  localparam logic [ENTRY_W-1:0] ENTRY_LAST = 4'd11;
  localparam logic [STEP_W-1:0]  STEP_STORE = STEP_W'(DIV_STEPS + 1);

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  value;
    logic [8:0]  ppu_cycle;
    logic [8:0]  scanline;
    logic        show_background;
    logic        show_sprites;
  } req_word_t;

  typedef struct packed {
    logic [1:0]          target;
    logic [OFFSET_W-1:0] mapped_offset;
    logic                write_strobe;
    logic                irq_pulse;
    logic                mirror_horizontal;
  } rsp_word_t;

  typedef struct packed {
    logic               item_load;
    logic               cfg_write;
    logic               exec;
    logic               rem_load;
    logic               rem_step;
    logic               rem_store;
    logic [ENTRY_W-1:0] entry;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bank_write;
    logic rsp_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bsm_rem.sv -----
`default_nettype none

module bsm_rem (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic                       step,
  input  wire logic [bsm_pkg::BANK_W-1:0] operand,
  input  wire logic [bsm_pkg::CHR_N_W-1:0] divisor,
  output logic [bsm_pkg::BANK_W-1:0]      bank_idx
);
  import bsm_pkg::*;

  logic                 neg;
  logic [BANK_W-1:0]    mag;
  logic [CHR_N_W-1:0]   rem;
  logic [CHR_N_W-1:0]   div;
  logic [CHR_N_W:0]     trial;

  // One quotient bit per step, restoring form on the magnitude
  assign trial = {rem, mag[BANK_W-1]};

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= operand[BANK_W-1];
      mag <= operand[BANK_W-1] ? BANK_W'(-operand) : operand;
      rem <= '0;
      div <= divisor;
    end else if (step) begin
      mag <= {mag[BANK_W-2:0], 1'b0};
      if (trial >= {1'b0, div}) begin
        rem <= CHR_N_W'(trial - {1'b0, div});
      end else begin
        rem <= trial[CHR_N_W-1:0];
      end
    end
  end

  // Negative remainder wraps by one full memory length
  always_comb begin
    if (neg && (rem != '0)) begin
      bank_idx = BANK_W'(div - rem);
    end else begin
      bank_idx = rem[BANK_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bsm_ctrl.sv -----
`default_nettype none

module bsm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire bsm_pkg::dp_status_t status,
  output bsm_pkg::ctrl_cmd_t       cmd
);
  import bsm_pkg::*;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t             state;
  logic [ENTRY_W-1:0] entry;
  logic [STEP_W-1:0]  step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      entry <= '0;
      step  <= '0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          if (step == STEP_STORE) begin
            step <= '0;
            if (entry == ENTRY_LAST) begin
              entry <= '0;
              state <= S_IDLE;
            end else begin
              entry <= entry + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_IDLE: begin
          if (cfg_valid) begin
            state <= S_SWEEP;
          end else if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (status.rsp_free) begin
            state <= status.bank_write ? S_SWEEP : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready = (state == S_IDLE);
  assign req_stall = (state != S_IDLE) || cfg_valid;

  always_comb begin
    cmd           = '0;
    cmd.entry     = entry;
    cmd.cfg_write = (state == S_IDLE) && cfg_valid;
    cmd.item_load = (state == S_IDLE) && !cfg_valid && req_valid;
    cmd.exec      = (state == S_EXEC) && status.rsp_free;
    cmd.rem_load  = (state == S_SWEEP) && (step == '0);
    cmd.rem_step  = (state == S_SWEEP) && (step != '0) && (step != STEP_STORE);
    cmd.rem_store = (state == S_SWEEP) && (step == STEP_STORE);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bsm_dp.sv -----
`default_nettype none

module bsm_dp #(
  parameter int PRG_OFFSET_BITS = bsm_pkg::PRG_OFFSET_BITS_DEF,
  parameter int CHR_OFFSET_BITS = bsm_pkg::CHR_OFFSET_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bsm_pkg::ctrl_cmd_t             cmd,
  output bsm_pkg::dp_status_t                 status,
  input  wire bsm_pkg::req_word_t             req_word,
  input  wire logic [bsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output bsm_pkg::rsp_word_t                  rsp_word
);
  import bsm_pkg::*;

  req_word_t            item;
  logic [PRG_N_W-1:0]   prg_n;
  logic [CHR_N_W-1:0]   chr_n;
  logic [2:0]           bank_sel;
  logic                 prg_mode;
  logic                 chr_mode;
  logic [BANK_W-1:0]    bank_val [8];
  logic [BANK_W-1:0]    irq_reload;
  logic [BANK_W-1:0]    irq_counter;
  logic                 irq_en;
  logic                 mirror;

  // Bank indexes after wrap; character in pair order, program as r6, r7, -2, -1
  logic [BANK_W-1:0]    chr_idx [8];
  logic [PRG_IDX_W-1:0] prg_idx [4];

  logic [BANK_W-1:0]    rem_operand;
  logic [CHR_N_W-1:0]   rem_divisor;
  logic [BANK_W-1:0]    rem_idx;

  rsp_word_t            res;
  logic [2:0]           bank_sel_next;
  logic                 prg_mode_next;
  logic                 chr_mode_next;
  logic                 bank_we;
  logic [BANK_W-1:0]    irq_reload_next;
  logic [BANK_W-1:0]    irq_counter_next;
  logic                 irq_en_next;
  logic                 mirror_next;
  logic [2:0]           chr_slot;
  logic [1:0]           prg_slot;
  logic [CHR_OFFSET_BITS-1:0] chr_win;
  logic [PRG_OFFSET_BITS-1:0] prg_win;
  logic                 counted;
  logic [PRG_N_W-1:0]   prg_cfg;
  logic [CHR_N_W-1:0]   chr_cfg;

  bsm_rem u_rem (
    .clk      (clk),
    .load     (cmd.rem_load),
    .step     (cmd.rem_step),
    .operand  (rem_operand),
    .divisor  (rem_divisor),
    .bank_idx (rem_idx)
  );

  always_comb begin
    unique case (cmd.entry)
      4'd0:    rem_operand = bank_val[0] & 8'hFE;
      4'd1:    rem_operand = bank_val[0] | 8'h01;
      4'd2:    rem_operand = bank_val[1] & 8'hFE;
      4'd3:    rem_operand = bank_val[1] | 8'h01;
      4'd4:    rem_operand = bank_val[2];
      4'd5:    rem_operand = bank_val[3];
      4'd6:    rem_operand = bank_val[4];
      4'd7:    rem_operand = bank_val[5];
      4'd8:    rem_operand = bank_val[6];
      4'd9:    rem_operand = bank_val[7];
      4'd10:   rem_operand = PRG_BANK_SECOND_LAST;
      4'd11:   rem_operand = PRG_BANK_LAST;
      default: rem_operand = '0;
    endcase
    rem_divisor = cmd.entry[3] ? CHR_N_W'(prg_n) : chr_n;
  end

  // Saturate bank counts into the used range
  always_comb begin
    prg_cfg = cfg_data[PRG_N_W-1:0];
    if (prg_cfg < PRG_N_MIN) begin
      prg_cfg = PRG_N_MIN;
    end else if (prg_cfg > PRG_N_MAX) begin
      prg_cfg = PRG_N_MAX;
    end
    chr_cfg = cfg_data;
    if (chr_cfg < CHR_N_MIN) begin
      chr_cfg = CHR_N_MIN;
    end else if (chr_cfg > CHR_N_MAX) begin
      chr_cfg = CHR_N_MAX;
    end
  end

  // Window selection follows the mode bits
  assign chr_slot = {item.address[12] ^ chr_mode, item.address[11:10]};
  assign prg_slot = item.address[13] ? item.address[14:13]
                                     : {item.address[14] ^ prg_mode, 1'b0};
  assign chr_win  = CHR_OFFSET_BITS'({chr_idx[chr_slot], 10'b0});
  assign prg_win  = PRG_OFFSET_BITS'({prg_idx[prg_slot], 13'b0});
  assign counted  = (item.ppu_cycle == IRQ_DOT)
                 && !((item.scanline >= VBLANK_FIRST) && (item.scanline <= VBLANK_LAST))
                 && (item.show_background || item.show_sprites);

  always_comb begin
    res              = '0;
    bank_sel_next    = bank_sel;
    prg_mode_next    = prg_mode;
    chr_mode_next    = chr_mode;
    bank_we          = 1'b0;
    irq_reload_next  = irq_reload;
    irq_counter_next = irq_counter;
    irq_en_next      = irq_en;
    mirror_next      = mirror;
    unique case (item.command)
      CMD_READ, CMD_WRITE: begin
        priority if (item.address < 16'h2000) begin
          res.target        = TGT_CHR;
          res.mapped_offset = OFFSET_W'(chr_win) + OFFSET_W'(item.address[9:0]);
          res.write_strobe  = (item.command == CMD_WRITE);
        end else if (item.address[15]) begin
          if (item.command == CMD_WRITE) begin
            unique case (item.address[14:13])
              2'b00: begin
                if (!item.address[0]) begin
                  prg_mode_next = item.value[6];
                  chr_mode_next = item.value[7];
                  bank_sel_next = item.value[2:0];
                end else begin
                  bank_we = 1'b1;
                end
              end
              2'b01: begin
                if (!item.address[0]) begin
                  mirror_next = item.value[0];
                end
              end
              2'b10: begin
                if (!item.address[0]) begin
                  irq_reload_next = item.value;
                end else begin
                  irq_counter_next = '0;
                end
              end
              default: irq_en_next = item.address[0];
            endcase
          end else begin
            res.target        = TGT_PRG;
            res.mapped_offset = OFFSET_W'(prg_win) + OFFSET_W'(item.address[12:0]);
          end
        end else if (item.address >= 16'h6000) begin
          res.target        = TGT_SRAM;
          res.mapped_offset = OFFSET_W'(item.address[12:0]);
          res.write_strobe  = (item.command == CMD_WRITE);
        end else begin
          // Unmapped hole between the character space and save RAM
          res.target = TGT_NONE;
        end
      end
      CMD_VIDEO: begin
        if (counted) begin
          if (irq_counter == '0) begin
            irq_counter_next = irq_reload;
          end else begin
            irq_counter_next = irq_counter - 1'b1;
            res.irq_pulse    = (irq_counter == 8'd1) && irq_en;
          end
        end
      end
      default: ;
    endcase
    res.mirror_horizontal = mirror_next;
  end

  assign status.bank_write = (item.command == CMD_WRITE) && item.address[15]
                          && (item.address[14:13] == 2'b00) && item.address[0];
  assign status.rsp_free   = !rsp_valid || !rsp_stall;

  // Mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_n       <= PRG_N_MIN;
      chr_n       <= CHR_N_MIN;
      bank_sel    <= '0;
      prg_mode    <= 1'b0;
      chr_mode    <= 1'b0;
      irq_reload  <= '0;
      irq_counter <= '0;
      irq_en      <= 1'b0;
      mirror      <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_val[i] <= '0;
      end
    end else begin
      if (cmd.cfg_write) begin
        unique case (cfg_index)
          CFG_PRG_BANK_COUNT: prg_n <= prg_cfg;
          CFG_CHR_BANK_COUNT: chr_n <= chr_cfg;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        bank_sel    <= bank_sel_next;
        prg_mode    <= prg_mode_next;
        chr_mode    <= chr_mode_next;
        irq_reload  <= irq_reload_next;
        irq_counter <= irq_counter_next;
        irq_en      <= irq_en_next;
        mirror      <= mirror_next;
        if (bank_we) begin
          bank_val[bank_sel] <= item.value;
        end
      end
    end
  end

  // Item capture and bank index store
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item <= req_word;
    end
    if (cmd.rem_store) begin
      if (cmd.entry[3]) begin
        prg_idx[cmd.entry[1:0]] <= rem_idx[PRG_IDX_W-1:0];
      end else begin
        chr_idx[cmd.entry[2:0]] <= rem_idx;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_word <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bank_switch_mapper_with_scanline_irq.sv -----
// Bank-switching memory mapper with scanline interrupt counter. Each request word
// is a bus read, a bus write, a video step or a no-op; each yields exactly one
// response word with target memory, mapped byte offset, write strobe, IRQ pulse
// and the current mirroring. A word is accepted into the item register, then
// executed into the response register once that is free; the response register
// holds a finished word while the next request is accepted. Bank counts may be
// 2 to 64 program and 8 to 256 character banks, so each window's bank index is a
// signed remainder by the count, worked out by a shared remainder unit one
// quotient bit per cycle in a sweep over all 12 windows. The sweep runs after
// reset, after every configuration write and after every bank data write (odd
// address in 0x8000..0x9FFF); no request is accepted meanwhile. Bank select
// writes set mode bits and the next bank data target, and cost no sweep.
// Configuration writes are taken only while idle and win over a request
// presented in the same cycle. The external memories are not part of this block.
`default_nettype none

module bank_switch_mapper_with_scanline_irq #(
  parameter int PRG_OFFSET_BITS = bsm_pkg::PRG_OFFSET_BITS_DEF,
  parameter int CHR_OFFSET_BITS = bsm_pkg::CHR_OFFSET_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire bsm_pkg::req_word_t              req_word,
  // response channel
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output bsm_pkg::rsp_word_t                   rsp_word,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bsm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence accept, execute and the remainder sweep
  bsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold mapper registers, window indexes and the response register
  bsm_dp #(
    .PRG_OFFSET_BITS (PRG_OFFSET_BITS),
    .CHR_OFFSET_BITS (CHR_OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_word  (req_word),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bsm_check.sv -----
`default_nettype none

module bsm_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_stall,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire bsm_pkg::rsp_word_t rsp_word
);
  import bsm_pkg::*;

  // Reset starts the window sweep, so requests wait
  a_reset_sweep: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request accepted right after reset");

  // One item at a time: an accepted word stalls the request channel in the following cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous one executes");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("stalled response changed");

  a_no_target_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.target == TGT_NONE)
      |-> (rsp_word.mapped_offset == '0) && !rsp_word.write_strobe)
    else $error("response without target carries offset or strobe");

  a_access_no_irq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.target != TGT_NONE) |-> !rsp_word.irq_pulse)
    else $error("memory access raised an interrupt");

endmodule

bind bank_switch_mapper_with_scanline_irq bsm_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_word  (rsp_word)
);

`default_nettype wire

// ----- dv/bank_switch_mapper_with_scanline_irq_tb.sv -----
module bank_switch_mapper_with_scanline_irq_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsm_pkg::*;

  // Mapper register bases on the bus; bit 0 of the address picks the odd twin
  localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [15:0] REG_MIRRORING   = 16'hA000;
  localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE000;

  // Config indexes past the two real registers: writes land nowhere
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int WORDS_PER_PHASE = 128;
  localparam int NUM_PHASES      = 9;
  localparam int SETTLE_CYCLES   = 150;
  localparam int TIMEOUT_NS      = 800_000;
  localparam int REQ_W           = $bits(req_word_t);

  // Mapper behavior: bank windows, registers and scanline counter, plus the
  // queue of response words still owed by the block.
  class mapper_scoreboard;
    rsp_word_t  owed_q[$];
    int         failures;
    int         reported;
    bit [6:0]   prg_count;
    bit [8:0]   chr_count;
    bit [2:0]   bank_sel;
    bit         prg_mode;
    bit         chr_mode;
    bit [7:0]   banks[8];
    bit [7:0]   irq_latch;
    bit [7:0]   irq_counter;
    bit         irq_on;
    bit         mirror;

    function new();
      prg_count = 7'd2;
      chr_count = 9'd8;
    endfunction

    function void apply_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PRG_BANK_COUNT) prg_count = data[6:0];
      else if (idx == CFG_CHR_BANK_COUNT) chr_count = data;
    endfunction

    // Signed bank number, truncating remainder, then wrap by the memory length
    function int bank_offset(int idx, int n, int size);
      int sidx;
      int rem;
      int off;
      sidx = (idx >= 128) ? idx - 256 : idx;
      rem = sidx % n;
      off = rem * size;
      if (off < 0) off += n * size;
      return off;
    endfunction

    function int prg_window(int slot);
      int n;
      int idx;
      n = (prg_count < 2) ? 2 : (prg_count > 64 ? 64 : int'(prg_count));
      case (slot)
        0: idx = prg_mode ? -2 : int'(banks[6]);
        1: idx = int'(banks[7]);
        2: idx = prg_mode ? int'(banks[6]) : -2;
        default: idx = -1;
      endcase
      return bank_offset(idx, n, 8192) & ((1 << PRG_OFFSET_BITS_DEF) - 1);
    endfunction

    function int chr_window(int slot);
      int n;
      int part;
      int v;
      n = (chr_count < 8) ? 8 : (chr_count > 256 ? 256 : int'(chr_count));
      part = slot % 4;
      if ((slot / 4) == (chr_mode ? 1 : 0)) begin
        v = (part < 2) ? int'(banks[0]) : int'(banks[1]);
        v = (part % 2) ? (v | 1) : (v & 'hFE);
      end else begin
        v = int'(banks[2 + part]);
      end
      return bank_offset(v, n, 1024) & ((1 << CHR_OFFSET_BITS_DEF) - 1);
    endfunction

    function void write_mapper_reg(logic [15:0] addr, logic [7:0] v);
      if (addr <= 16'h9FFF) begin
        if (!addr[0]) begin
          prg_mode = v[6];
          chr_mode = v[7];
          bank_sel = v[2:0];
        end else begin
          banks[bank_sel] = v;
        end
      end else if (addr <= 16'hBFFF) begin
        if (!addr[0]) mirror = v[0];
      end else if (addr <= 16'hDFFF) begin
        if (!addr[0]) irq_latch = v;
        else irq_counter = '0;
      end else begin
        irq_on = addr[0];
      end
    endfunction

    function bit clock_scanline();
      if (irq_counter == 0) begin
        irq_counter = irq_latch;
        return 0;
      end
      irq_counter = irq_counter - 8'd1;
      return (irq_counter == 0) && irq_on;
    endfunction

    function void note_request(req_word_t w);
      rsp_word_t e;
      logic [15:0] rel;
      e = '0;
      case (w.command)
        CMD_READ, CMD_WRITE: begin
          if (w.address < 16'h2000) begin
            e.target = TGT_CHR;
            e.mapped_offset = OFFSET_W'(chr_window(int'(w.address[12:10]))
                                        + int'(w.address[9:0]));
            e.write_strobe = (w.command == CMD_WRITE);
          end else if (w.address >= 16'h8000) begin
            if (w.command == CMD_WRITE) begin
              write_mapper_reg(w.address, w.value);
            end else begin
              rel = w.address - 16'h8000;
              e.target = TGT_PRG;
              e.mapped_offset = OFFSET_W'(prg_window(int'(rel[14:13])) + int'(rel[12:0]));
            end
          end else if (w.address >= 16'h6000) begin
            e.target = TGT_SRAM;
            e.mapped_offset = OFFSET_W'(w.address - 16'h6000);
            e.write_strobe = (w.command == CMD_WRITE);
          end
        end
        CMD_VIDEO: begin
          if (w.ppu_cycle == IRQ_DOT &&
              !(w.scanline >= VBLANK_FIRST && w.scanline <= VBLANK_LAST) &&
              (w.show_background || w.show_sprites))
            e.irq_pulse = clock_scanline();
        end
        default: ;
      endcase
      e.mirror_horizontal = mirror;
      owed_q.push_back(e);
    endfunction

    function void check_response(rsp_word_t got);
      rsp_word_t want;
      if (owed_q.size() == 0) begin
        failures++;
        if (reported < 10)
          $display("response word with nothing owed: %h", got);
        reported++;
        return;
      end
      want = owed_q.pop_front();
      if (got.target !== want.target || got.mapped_offset !== want.mapped_offset ||
          got.write_strobe !== want.write_strobe || got.irq_pulse !== want.irq_pulse ||
          got.mirror_horizontal !== want.mirror_horizontal) begin
        failures++;
        if (reported < 10)
          $display("mismatch: target %0d/%0d offset %h/%h strobe %b/%b irq %b/%b mirror %b/%b",
                   want.target, got.target, want.mapped_offset, got.mapped_offset,
                   want.write_strobe, got.write_strobe, want.irq_pulse, got.irq_pulse,
                   want.mirror_horizontal, got.mirror_horizontal);
        reported++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void close_out();
      if (owed_q.size() != 0) begin
        failures++;
        $display("%0d response words never arrived", owed_q.size());
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  req_word_t              req_word;
  logic                   rsp_valid;
  logic                   rsp_stall;
  rsp_word_t              rsp_word;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mapper_scoreboard sb = new();

  // Idle rates in percent, and a long receiver hold-off requested by the stimulus
  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;
  int words_sent;

  bank_switch_mapper_with_scanline_irq dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake
  initial begin
    #TIMEOUT_NS;
    $display("status: fail");
    $finish;
  end

  // Sample both channels at the rising edge; note the request first, since its
  // response cannot leave the block in the same cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req_word);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp_word);
    end
  end

  // Receiver: stall at random, or hold off for a requested stretch of cycles
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        rsp_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(req_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_word = w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait for every owed response word
  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_config(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Access word; unused fields carry random noise the block must ignore
  function automatic req_word_t access(logic [1:0] cmd, logic [15:0] addr, logic [7:0] v);
    req_word_t w;
    w = REQ_W'({$urandom, $urandom});
    w.command = cmd;
    w.address = addr;
    w.value = v;
    return w;
  endfunction

  function automatic req_word_t video(int dot, int line, bit bg, bit sp);
    req_word_t w;
    w = REQ_W'({$urandom, $urandom});
    w.command = CMD_VIDEO;
    w.ppu_cycle = 9'(dot);
    w.scanline = 9'(line);
    w.show_background = bg;
    w.show_sprites = sp;
    return w;
  endfunction

  // Address in one mapper register's 8 KiB range with the given parity
  function automatic logic [15:0] reg_addr(logic [15:0] base, bit odd);
    return base | (16'($urandom_range(0, 16'h1FFF)) & 16'h1FFE) | 16'(odd);
  endfunction

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 16'h1FFF));
      3, 4, 5: return 16'($urandom_range(16'h8000, 16'hFFFF));
      6:       return 16'($urandom_range(16'h6000, 16'h7FFF));
      7:       return 16'($urandom_range(16'h2000, 16'h5FFF));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random traffic: mostly well-formed bank and IRQ programming sequences with
  // accesses between them, some noise words mixed in.
  task automatic run_random(int count);
    int goal;
    int roll;
    int steps;
    req_word_t w;
    goal = words_sent + count;
    while (words_sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        send_word(access(CMD_READ, pick_address(), 8'($urandom)));
      end else if (roll < 42) begin
        send_word(access(CMD_WRITE, pick_address(), 8'($urandom)));
      end else if (roll < 52) begin
        // bank select then bank data
        send_word(access(CMD_WRITE, reg_addr(REG_BANK_SELECT, 1'b0), 8'($urandom)));
        send_word(access(CMD_WRITE, reg_addr(REG_BANK_SELECT, 1'b1), 8'($urandom)));
      end else if (roll < 58) begin
        // mirroring or the inert write-protect twin
        send_word(access(CMD_WRITE, reg_addr(REG_MIRRORING, 1'($urandom)), 8'($urandom)));
      end else if (roll < 66) begin
        // arm the counter, then clock it through a few visible lines
        send_word(access(CMD_WRITE, reg_addr(REG_IRQ_LATCH, 1'b0),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5))));
        send_word(access(CMD_WRITE, reg_addr(REG_IRQ_LATCH, 1'b1), 8'($urandom)));
        send_word(access(CMD_WRITE, reg_addr(REG_IRQ_ENABLE, $urandom_range(0, 4) != 0),
                         8'($urandom)));
        steps = $urandom_range(2, 10);
        repeat (steps)
          send_word(video(IRQ_DOT, $urandom_range(0, 239), 1'($urandom), $urandom_range(0, 3) != 0));
      end else if (roll < 90) begin
        send_word(video(($urandom_range(0, 1) != 0) ? int'(IRQ_DOT) : $urandom_range(0, 340),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 261),
                        1'($urandom), 1'($urandom)));
      end else if (roll < 95) begin
        send_word(access(CMD_NOP, 16'($urandom), 8'($urandom)));
      end else begin
        w = REQ_W'({$urandom, $urandom});
        send_word(w);
      end
    end
  endtask

  int prg_setting[NUM_PHASES] = '{64, 0, 127, 5, 2, 33, 'h1C3, 17, 0};
  int chr_setting[NUM_PHASES] = '{256, 0, 511, 37, 8, 200, 257, 129, 0};

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_len = 0;
    words_sent = 0;
    send_idle_pct = 26;
    recv_stall_pct = 58;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: window edges, every region, each register and the counter corners
    send_word(access(CMD_READ, 16'h0000, 8'h00));
    send_word(access(CMD_WRITE, 16'h1FFF, 8'hFF));
    send_word(access(CMD_READ, 16'h8000, 8'h00));
    send_word(access(CMD_READ, 16'hFFFF, 8'h00));
    send_word(access(CMD_READ, 16'h6000, 8'h00));
    send_word(access(CMD_WRITE, 16'h7FFF, 8'hFF));
    send_word(access(CMD_READ, 16'h2000, 8'h00));
    send_word(access(CMD_WRITE, 16'h5FFF, 8'hAA));
    send_word(access(CMD_WRITE, REG_BANK_SELECT, 8'hC7));
    send_word(access(CMD_WRITE, REG_BANK_SELECT | 16'h0001, 8'h80));
    send_word(access(CMD_READ, 16'hA000, 8'h00));
    send_word(access(CMD_READ, 16'hC123, 8'h00));
    send_word(access(CMD_WRITE, REG_BANK_SELECT, 8'h00));
    send_word(access(CMD_WRITE, REG_BANK_SELECT | 16'h0001, 8'hFF));
    send_word(access(CMD_READ, 16'h0400, 8'h00));
    send_word(access(CMD_WRITE, REG_MIRRORING, 8'h01));
    send_word(access(CMD_WRITE, REG_MIRRORING | 16'h0001, 8'hFE));
    send_word(access(CMD_WRITE, REG_IRQ_LATCH, 8'h01));
    send_word(access(CMD_WRITE, REG_IRQ_LATCH | 16'h0001, 8'h00));
    send_word(access(CMD_WRITE, REG_IRQ_ENABLE | 16'h0001, 8'h00));
    send_word(video(IRQ_DOT, 0, 1'b1, 1'b0));
    send_word(video(IRQ_DOT, 261, 1'b0, 1'b1));
    send_word(video(IRQ_DOT, VBLANK_FIRST, 1'b1, 1'b1));
    send_word(video(IRQ_DOT - 1, 10, 1'b1, 1'b1));
    send_word(video(IRQ_DOT, 10, 1'b0, 1'b0));
    send_word(access(CMD_WRITE, REG_IRQ_ENABLE, 8'h00));
    send_word(access(CMD_NOP, 16'hFFFF, 8'hFF));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Sender idles lightly first, then heavily, then never
      if (phase < 3) begin
        send_idle_pct = 26;
        recv_stall_pct = 58;
      end else if (phase < 6) begin
        send_idle_pct = 58;
        recv_stall_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      drain();
      if (phase == NUM_PHASES - 1) begin
        write_config(CFG_PRG_BANK_COUNT, CFG_DATA_W'($urandom_range(2, 64)));
        write_config(CFG_CHR_BANK_COUNT, CFG_DATA_W'($urandom_range(8, 256)));
      end else begin
        write_config(CFG_PRG_BANK_COUNT, CFG_DATA_W'(prg_setting[phase]));
        write_config(CFG_CHR_BANK_COUNT, CFG_DATA_W'(chr_setting[phase]));
      end
      if (phase == 2) begin
        write_config(CFG_SPARE_A, 9'($urandom));
        write_config(CFG_SPARE_B, 9'h1FF);
      end
      if (phase == 1) begin
        // Hold the response side while words keep coming, so the input backs up
        run_random(40);
        hold_len = 90;
        run_random(WORDS_PER_PHASE - 40);
      end else if (phase == 4) begin
        // Pause mid-phase until the block has returned everything
        run_random(60);
        drain();
        run_random(WORDS_PER_PHASE - 60);
      end else begin
        run_random(WORDS_PER_PHASE);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_rem.sv
hw/rtl/bsm_ctrl.sv
hw/rtl/bsm_dp.sv
hw/rtl/bank_switch_mapper_with_scanline_irq.sv
hw/rtl/bsm_check.sv
dv/bank_switch_mapper_with_scanline_irq_tb.sv
